// ===== sv/bgr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, constants and glyph geometry tables for the scaled bitmap
// glyph renderer.
// ----------------------------------------------------------------------------
package bgr_pkg;

    // field widths fixed by the interface
    localparam int FADDR_W   = 13;
    localparam int CODE_W    = 8;
    localparam int DIM_IN_W  = 7;
    localparam int ROW_W     = 64;
    localparam int ROWIDX_W  = 6;

    // fixed-point scale step
    localparam int FRAC_BITS = 16;
    localparam int GDIM_W    = 6;
    localparam int STEP_W    = GDIM_W + FRAC_BITS;
    localparam int SX_W      = 4;
    localparam int SY_W      = 5;
    localparam int ROWB_W    = 7;

    localparam logic [CODE_W-1:0] CODE_LIMIT = 8'h7f;
    localparam logic [7:0]        PIX_MSB    = 8'h80;

    // item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // font size register codes
    localparam logic [1:0] SIZE_8X16  = 2'd0;
    localparam logic [1:0] SIZE_10X20 = 2'd1;
    localparam logic [1:0] SIZE_12X24 = 2'd2;
    localparam logic [1:0] SIZE_16X32 = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]   char_code;
        logic [DIM_IN_W-1:0] out_width;
        logic [DIM_IN_W-1:0] out_height;
    } bgr_req_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_COL  = 8'b0000_0100,
        S_RD0  = 8'b0000_1000,
        S_RD1  = 8'b0001_0000,
        S_RD2  = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_REJ  = 8'b1000_0000
    } bgr_state_t;

    function automatic logic [GDIM_W-1:0] glyph_w(input logic [1:0] sel);
        logic [GDIM_W-1:0] w;
        unique case (sel)
            SIZE_8X16:  w = 6'd8;
            SIZE_10X20: w = 6'd10;
            SIZE_12X24: w = 6'd12;
            SIZE_16X32: w = 6'd16;
        endcase
        return w;
    endfunction

    function automatic logic [GDIM_W-1:0] glyph_h(input logic [1:0] sel);
        logic [GDIM_W-1:0] h;
        unique case (sel)
            SIZE_8X16:  h = 6'd16;
            SIZE_10X20: h = 6'd20;
            SIZE_12X24: h = 6'd24;
            SIZE_16X32: h = 6'd32;
        endcase
        return h;
    endfunction

    // bytes per glyph: height times bytes per glyph row
    function automatic logic [ROWB_W-1:0] glyph_bytes(input logic [1:0] sel);
        logic [ROWB_W-1:0] b;
        unique case (sel)
            SIZE_8X16:  b = 7'd16;
            SIZE_10X20: b = 7'd40;
            SIZE_12X24: b = 7'd48;
            SIZE_16X32: b = 7'd64;
        endcase
        return b;
    endfunction

    // two bytes per glyph row for every width above 8
    function automatic logic two_byte_row(input logic [1:0] sel);
        return (sel != SIZE_8X16);
    endfunction

    // pixel sx of a glyph row held msb-first in two bytes
    function automatic logic glyph_bit(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [SX_W-1:0] sx);
        logic [7:0] b;
        logic [7:0] m;
        b = sx[3] ? b1 : b0;
        m = PIX_MSB >> sx[2:0];
        return |(b & m);
    endfunction

endpackage
`default_nettype wire

// ===== sv/bgr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== sv/bgr_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgr_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quo_reg;

endmodule
`default_nettype wire

// ===== sv/bgr_render.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_render
// Render sequencer: step division, column map build, row fetch from the
// font memory and the output word register.
// ----------------------------------------------------------------------------
module bgr_render #(
    parameter int FONT_BYTES  = 8192,
    parameter int MAX_OUT_DIM = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bgr_pkg::bgr_req_t             req,
    input  logic [1:0]                    size_sel,
    output logic                          idle,
    output logic                          rd_en,
    output logic [$clog2(FONT_BYTES)-1:0] rd_addr,
    input  logic [7:0]                    rd_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bgr_pkg::ROWIDX_W-1:0]  row_index,
    output logic [bgr_pkg::ROW_W-1:0]     row_pixels,
    output logic                          last_row,
    output logic                          status
);

    import bgr_pkg::*;

    localparam int AW     = $clog2(FONT_BYTES);
    localparam int DIM_W  = $clog2(MAX_OUT_DIM + 1);
    localparam int IDX_W  = $clog2(MAX_OUT_DIM);
    localparam int WRAP_W = ((FADDR_W > AW) ? FADDR_W : AW) + 2;
    localparam logic [WRAP_W-1:0] F1 = WRAP_W'(FONT_BYTES);
    localparam logic [WRAP_W-1:0] F2 = WRAP_W'(2 * FONT_BYTES);

    bgr_state_t state_reg, state_next;

    logic [DIM_W-1:0]   ow_reg, oh_reg, ow_next, oh_next;
    logic [DIM_W-1:0]   dy_reg, col_reg;
    logic [FADDR_W-1:0] base_reg;
    logic [13:0]        base_prod;
    logic [STEP_W-1:0]  xpos_reg, ypos_reg, xstep, ystep;
    logic [SX_W-1:0]    colmap_reg [MAX_OUT_DIM];
    logic [MAX_OUT_DIM-1:0] col_en_reg;
    logic [7:0]         byte0_reg, byte1_reg;

    logic                out_valid_reg, last_row_reg, status_reg;
    logic [ROWIDX_W-1:0] row_index_reg;
    logic [ROW_W-1:0]    row_pixels_reg, pix;

    logic code_ok, div_start, x_busy, y_busy, out_free, dy_last, col_last, wide;
    logic [GDIM_W-1:0] gw, gh;
    logic [SY_W-1:0]   sy;
    logic [SY_W:0]     sy_off;
    logic [WRAP_W-1:0] addr_raw, addr_a, addr_b;

    assign gw        = glyph_w(size_sel);
    assign gh        = glyph_h(size_sel);
    assign wide      = two_byte_row(size_sel);
    assign code_ok   = (req.char_code < CODE_LIMIT);
    assign div_start = start && code_ok;

    // 0 counts as 1, anything above the maximum counts as the maximum
    always_comb
    begin
        if (req.out_width == '0)
            ow_next = DIM_W'(1);
        else if (req.out_width > DIM_IN_W'(MAX_OUT_DIM))
            ow_next = DIM_W'(MAX_OUT_DIM);
        else
            ow_next = DIM_W'(req.out_width);
        if (req.out_height == '0)
            oh_next = DIM_W'(1);
        else if (req.out_height > DIM_IN_W'(MAX_OUT_DIM))
            oh_next = DIM_W'(MAX_OUT_DIM);
        else
            oh_next = DIM_W'(req.out_height);
    end

    assign base_prod = req.char_code[6:0] * glyph_bytes(size_sel);

    bgr_div #(.NUM_W(STEP_W), .DEN_W(DIM_W)) u_xdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({gw, {FRAC_BITS{1'b0}}}),
        .den   (ow_next),
        .busy  (x_busy),
        .quot  (xstep)
    );

    bgr_div #(.NUM_W(STEP_W), .DEN_W(DIM_W)) u_ydiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({gh, {FRAC_BITS{1'b0}}}),
        .den   (oh_next),
        .busy  (y_busy),
        .quot  (ystep)
    );

    // font row address, wrapped into the store
    assign sy       = ypos_reg[FRAC_BITS +: SY_W];
    assign sy_off   = wide ? {sy, 1'b0} : {1'b0, sy};
    assign addr_raw = WRAP_W'(base_reg) + WRAP_W'(sy_off) + WRAP_W'(state_reg == S_RD1);
    assign addr_a   = (addr_raw >= F2) ? addr_raw - F2 : addr_raw;
    assign addr_b   = (addr_a >= F1) ? addr_a - F1 : addr_a;
    assign rd_addr  = addr_b[AW-1:0];
    assign rd_en    = (state_reg == S_RD0) || (state_reg == S_RD1);

    assign out_free = !out_valid_reg || out_ready;
    assign dy_last  = (dy_reg == oh_reg - DIM_W'(1));
    assign col_last = (col_reg == ow_reg - DIM_W'(1));

    for (genvar x = 0; x < ROW_W; x++)
    begin : g_pix
        if (x < MAX_OUT_DIM)
        begin : g_col
            assign pix[x] = col_en_reg[x] & glyph_bit(byte0_reg, byte1_reg, colmap_reg[x]);
        end
        else
        begin : g_pad
            assign pix[x] = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = code_ok ? S_DIV : S_REJ;
            S_DIV:
                if (!x_busy && !y_busy)
                    state_next = S_COL;
            S_COL:
                if (col_last)
                    state_next = S_RD0;
            S_RD0:
                state_next = S_RD1;
            S_RD1:
                state_next = wide ? S_RD2 : S_EMIT;
            S_RD2:
                state_next = S_EMIT;
            S_EMIT:
                if (out_free)
                    state_next = dy_last ? S_IDLE : S_RD0;
            S_REJ:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dy_reg        <= '0;
            col_reg       <= '0;
            col_en_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                dy_reg     <= '0;
                col_reg    <= '0;
                col_en_reg <= '0;
            end
            if (state_reg == S_COL)
            begin
                col_reg                         <= col_reg + DIM_W'(1);
                col_en_reg[col_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (state_reg == S_EMIT && out_free)
            begin
                dy_reg <= dy_reg + DIM_W'(1);
            end
            if ((state_reg == S_EMIT || state_reg == S_REJ) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    ow_reg   <= ow_next;
                    oh_reg   <= oh_next;
                    base_reg <= base_prod[FADDR_W-1:0];
                    xpos_reg <= '0;
                    ypos_reg <= '0;
                end
            S_COL:
            begin
                colmap_reg[col_reg[IDX_W-1:0]] <= xpos_reg[FRAC_BITS +: SX_W];
                xpos_reg                        <= xpos_reg + xstep;
            end
            S_RD1:
                byte0_reg <= rd_data;
            S_RD2:
                byte1_reg <= rd_data;
            S_EMIT:
                if (out_free)
                begin
                    ypos_reg       <= ypos_reg + ystep;
                    row_index_reg  <= ROWIDX_W'(dy_reg);
                    row_pixels_reg <= pix;
                    last_row_reg   <= dy_last;
                    status_reg     <= 1'b0;
                end
            S_REJ:
                if (out_free)
                begin
                    row_index_reg  <= '0;
                    row_pixels_reg <= '0;
                    last_row_reg   <= 1'b1;
                    status_reg     <= 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    assign idle       = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign row_index  = row_index_reg;
    assign row_pixels = row_pixels_reg;
    assign last_row   = last_row_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COL) |-> (!x_busy && !y_busy))
        else $error("column build started before step division finished");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COL) |-> (col_reg < ow_reg))
        else $error("column map index beyond output width");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (dy_reg < oh_reg))
        else $error("row count beyond output height");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && dy_last) |=> (state_reg == S_IDLE))
        else $error("render did not end after its last row");

    a_reject_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (last_row_reg && row_index_reg == '0))
        else $error("rejected word is not a single final row");
`endif

endmodule
`default_nettype wire

// ===== sv/bitmap_glyph_render_scaled_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_glyph_render_scaled_top
// Character generator with a byte-wide font memory and nearest-neighbor
// scaling of glyphs to a requested output size, one word per output row.
// ----------------------------------------------------------------------------
//
//  channel   handshake                   payload
//  -------   -------------------------   -------------------------------------
//  input     in_valid / in_ready         func font_addr font_byte char_code
//                                        out_width out_height
//  output    out_valid / out_ready       row_index row_pixels last_row status
//  config    cfg_wr_en (no wait)         cfg_wr_data (font size select)
//
//  a load word is written as it is accepted; a rejected code passes the reject
//  step, going idle as its status word enters the output register; a render
//  runs the bit-serial step dividers, builds the column map, then per row reads
//  one byte (8 wide) or two via the single font read port, one byte per cycle
//  the font memory has no reset and no clearing pass; reset clears control
//  a stalled output holds the sequencer only in its emit or reject step; the
//  next input word is taken as soon as the last row is in the output register
//
module bitmap_glyph_render_scaled_top #(
    parameter int FONT_BYTES  = 8192,
    parameter int MAX_OUT_DIM = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_wr_data,
    // input words
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [bgr_pkg::FADDR_W-1:0]   font_addr,
    input  logic [7:0]                    font_byte,
    input  logic [bgr_pkg::CODE_W-1:0]    char_code,
    input  logic [bgr_pkg::DIM_IN_W-1:0]  out_width,
    input  logic [bgr_pkg::DIM_IN_W-1:0]  out_height,
    // output words
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bgr_pkg::ROWIDX_W-1:0]  row_index,
    output logic [bgr_pkg::ROW_W-1:0]     row_pixels,
    output logic                          last_row,
    output logic                          status
);

    import bgr_pkg::*;

    localparam int AW = $clog2(FONT_BYTES);

    logic [1:0]    size_sel_reg;
    logic          in_acc;
    logic          load_we;
    logic          render_start;
    logic          render_idle;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    bgr_req_t      req;

    // font size select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_sel_reg <= SIZE_8X16;
        else if (cfg_wr_en)
            size_sel_reg <= cfg_wr_data;
    end

    // one word at a time: the sequencer takes nothing while a render runs
    assign in_ready = render_idle;
    assign in_acc   = in_valid && in_ready;

    // loads beyond the end of the store are dropped
    assign load_we      = in_acc && (func == FUNC_LOAD) && (32'(font_addr) < 32'(FONT_BYTES));
    assign render_start = in_acc && (func == FUNC_RENDER);

    assign req.char_code  = char_code;
    assign req.out_width  = out_width;
    assign req.out_height = out_height;

    // writes land at the accept edge, before any later render read is issued
    bgr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(font_addr)),
        .wdata (font_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bgr_render #(.FONT_BYTES(FONT_BYTES), .MAX_OUT_DIM(MAX_OUT_DIM)) u_render (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (render_start),
        .req        (req),
        .size_sel   (size_sel_reg),
        .idle       (render_idle),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index),
        .row_pixels (row_pixels),
        .last_row   (last_row),
        .status     (status)
    );

endmodule
`default_nettype wire
